// ----- src/assert_macros.svh -----
// assertion macros shared by the hash block
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define LSH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define LSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/lsh_pkg.sv -----
// shared types, constants and mixing functions of the state hash block
// no dependencies; used by controller, datapath and top level
package lsh_pkg;

   localparam logic [7:0] MAX_BOTS = 8'd255;

   // operation codes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_TILE   = 2'd1;
   localparam logic [1:0] OP_BOT    = 2'd2;
   localparam logic [1:0] OP_FINISH = 2'd3;

   localparam logic [63:0] SEED_HASH  = 64'h3333333333333333;
   localparam logic [63:0] WON_MASK   = 64'hFFFF0000FFFF0000;
   localparam logic [63:0] NIB_HI     = 64'hF0F0F0F0F0F0F0F0;
   localparam logic [63:0] NIB_LO     = 64'h0F0F0F0F0F0F0F0F;
   localparam logic [31:0] LIN_A_HI   = 32'h12345678;
   localparam logic [31:0] LIN_A_LO   = 32'h09ABCDEF;
   localparam logic [63:0] LIN_A_XOR  = 64'h00112233FFEEDDCC;
   localparam logic [63:0] LIN_B_XOR  = 64'h1F1F2E2E3D3D4C4C;
   localparam logic [31:0] LIN_B_HI   = 32'h19283746;
   localparam logic [31:0] LIN_B_LO   = 32'hF9E8D7C6;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch operands of an accepted item
      logic load_start;
      logic load_tile;
      logic load_bot;
      logic mul_b;
      logic mix_nl;
      logic mul_a;
      logic emit;
   } lsh_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bot_full;
      logic out_busy;
   } lsh_status_type;

   function automatic logic [63:0] rotr64(input logic [63:0] v, input logic [5:0] n);
      logic [127:0] d;
      d = {v, v} >> n;
      return d[63:0];
   endfunction

   function automatic logic [63:0] mix_nonlinear(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] s;
      r = rotr64(v, {1'b0, v[4:0]} + 6'd1);
      s = ((r & NIB_HI) >> 4) | ((r & NIB_LO) << 4);
      return {s[63:32], s[15:0], s[31:16]};
   endfunction

endpackage

// ----- src/lsh_req_if.sv -----
// input channel of the state hash block: valid, ready and item fields
// no dependencies
interface lsh_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [7:0]         guy_x;
   logic [7:0]         guy_y;
   logic [7:0]         tile_now;
   logic [7:0]         tile_original;
   logic [7:0]         bot_kind;
   logic [15:0]        bot_cell;
   logic signed [15:0] bot_attribute;
   logic               won_at_start;

   modport source (output valid, output operation, output guy_x, output guy_y,
                   output tile_now, output tile_original, output bot_kind,
                   output bot_cell, output bot_attribute, output won_at_start,
                   input ready);
   modport sink (input valid, input operation, input guy_x, input guy_y,
                 input tile_now, input tile_original, input bot_kind,
                 input bot_cell, input bot_attribute, input won_at_start,
                 output ready);
endinterface

// ----- src/lsh_rsp_if.sv -----
// result channel of the state hash block: valid, ready and state key
// no dependencies
interface lsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] state_key;

   modport source (output valid, output state_key, input ready);
   modport sink (input valid, input state_key, output ready);
endinterface

// ----- src/lsh_ctrl.sv -----
// sequencer of the state hash block: steps each item through the datapath
// depends on lsh_pkg and assert_macros.svh
`include "assert_macros.svh"

module lsh_ctrl
   import lsh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_operation,
   output logic           req_ready,
   input  lsh_status_type status,
   output lsh_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MULB  = 3'd1;
   localparam logic [2:0] ST_MIXNL = 3'd2;
   localparam logic [2:0] ST_MULA  = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.capture = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_START: begin
                     cmd.load_start = 1'b1;
                     state_in       = ST_MULA;
                  end
                  OP_TILE: begin
                     cmd.load_tile = 1'b1;
                     state_in      = ST_MULA;
                  end
                  OP_BOT: begin
                     // saturated bot count: item dropped
                     if (!status.bot_full) begin
                        cmd.load_bot = 1'b1;
                        state_in     = ST_MULB;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_MULB: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_MIXNL;
         end
         ST_MIXNL: begin
            cmd.mix_nl = 1'b1;
            state_in   = ST_MULA;
         end
         ST_MULA: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_FIN: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LSH_ASSERT_NOW(a_one_step, clock, reset, 1'b1, $onehot0({cmd.load_start, cmd.load_tile, cmd.load_bot, cmd.mul_b, cmd.mix_nl, cmd.mul_a, cmd.emit}))
   `LSH_ASSERT_NEXT(a_bot_chain, clock, reset, cmd.load_bot, state_ff == ST_MULB)
   `LSH_ASSERT_NEXT(a_mulb_to_mix, clock, reset, state_ff == ST_MULB, state_ff == ST_MIXNL)

endmodule

// ----- src/lsh_dp.sv -----
// datapath of the state hash block: hash, work and key registers, multipliers
// depends on lsh_pkg and assert_macros.svh
`include "assert_macros.svh"

module lsh_dp
   import lsh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  lsh_cmd_type        cmd,
   output lsh_status_type     status,
   input  logic [7:0]         req_guy_x,
   input  logic [7:0]         req_guy_y,
   input  logic [7:0]         req_tile_now,
   input  logic [7:0]         req_tile_original,
   input  logic [7:0]         req_bot_kind,
   input  logic [15:0]        req_bot_cell,
   input  logic signed [15:0] req_bot_attribute,
   input  logic               req_won_at_start,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [63:0]        rsp_state_key
);

   logic [63:0] hash_ff, hash_in;
   logic [63:0] work_ff, work_in;
   logic [7:0]  ord_ff, ord_in;
   logic [15:0] cell_ff;
   logic [15:0] attr_ff;
   logic        won_ff;
   logic [63:0] key_ff, key_in;
   logic        kvalid_ff, kvalid_in;

   logic [31:0] mul_k_hi;
   logic [31:0] mul_k_lo;
   logic [63:0] prod_hi;
   logic [63:0] prod_lo;
   logic [63:0] mix_prod;
   logic [63:0] key_raw;

   // shared 32x32 multiplier pair, constants picked per linear mix
   assign mul_k_hi = cmd.mul_b ? LIN_B_HI : LIN_A_HI;
   assign mul_k_lo = cmd.mul_b ? LIN_B_LO : LIN_A_LO;
   assign prod_hi  = {32'd0, work_ff[63:32]} * {32'd0, mul_k_hi};
   assign prod_lo  = {32'd0, work_ff[31:0]} * {32'd0, mul_k_lo};
   assign mix_prod = prod_hi | prod_lo;

   assign key_raw = hash_ff ^ (won_ff ? WON_MASK : 64'd0);

   always_comb begin
      hash_in   = hash_ff;
      work_in   = work_ff;
      ord_in    = ord_ff;
      key_in    = key_ff;
      kvalid_in = kvalid_ff && !rsp_ready;
      if (cmd.load_start) begin
         work_in = SEED_HASH ^ {25'd0, req_guy_x, 31'd0} ^ {56'd0, req_guy_y};
         ord_in  = 8'd0;
      end
      if (cmd.load_tile) begin
         work_in = mix_nonlinear(hash_ff ^ {56'd0, req_tile_now})
                   + {56'd0, req_tile_original};
      end
      if (cmd.load_bot) begin
         work_in = rotr64(hash_ff, ord_ff[5:0]) ^ {56'd0, req_bot_kind} ^ LIN_B_XOR;
         ord_in  = ord_ff + 8'd1;
      end
      if (cmd.mul_b) begin
         work_in = mix_prod;
      end
      if (cmd.mix_nl) begin
         work_in = mix_nonlinear(work_ff ^ {48'd0, cell_ff}) ^ {{48{attr_ff[15]}}, attr_ff};
      end
      if (cmd.mul_a) begin
         hash_in = mix_prod ^ LIN_A_XOR;
      end
      if (cmd.emit) begin
         key_in    = (key_raw == 64'd0) ? 64'd1 : key_raw;
         kvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff   <= SEED_HASH;
         ord_ff    <= 8'd0;
         kvalid_ff <= 1'b0;
      end else begin
         hash_ff   <= hash_in;
         ord_ff    <= ord_in;
         kvalid_ff <= kvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      key_ff  <= key_in;
      if (cmd.capture) begin
         cell_ff <= req_bot_cell;
         attr_ff <= req_bot_attribute;
         won_ff  <= req_won_at_start;
      end
   end

   assign status.bot_full = (ord_ff >= MAX_BOTS);
   assign status.out_busy = kvalid_ff && !rsp_ready;
   assign rsp_valid       = kvalid_ff;
   assign rsp_state_key   = key_ff;

   `LSH_ASSERT_NOW(a_key_nonzero, clock, reset, kvalid_ff, key_ff != 64'd0)
   `LSH_ASSERT_NOW(a_ord_bound, clock, reset, 1'b1, ord_ff <= MAX_BOTS)
   `LSH_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, kvalid_ff)

endmodule

// ----- src/level_state_hash.sv -----
// top level of the streaming puzzle-state hash
// depends on lsh_pkg, lsh_req_if, lsh_rsp_if, lsh_ctrl and lsh_dp
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    operation, guy_x, guy_y, tile_now, tile_original,
//                                bot_kind, bot_cell, bot_attribute, won_at_start
//   rsp      out  valid/ready    state_key (finish items only)
//
// steps per item: start and tile load, then multiply a; bot rotate/xor, multiply b,
// nonlinear mix, multiply a; finish emits after any wait on a key still held in rsp
// the bot path uses the single shared 32x32 multiplier pair twice
// a bot item past the saturated count is dropped in its transfer cycle
// synchronous reset loads the seed hash, clears the bot count and the key valid
// the key sits in an output register, so req may transfer while rsp stalls
module level_state_hash
   import lsh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   lsh_req_if.sink  req,
   lsh_rsp_if.source rsp
);

   lsh_cmd_type    cmd;
   lsh_status_type status;

   // sequencer: owns req ready and the step order
   lsh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_operation (req.operation),
      .req_ready     (req.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath: running hash, bot count, shared multipliers and key register
   lsh_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_guy_x         (req.guy_x),
      .req_guy_y         (req.guy_y),
      .req_tile_now      (req.tile_now),
      .req_tile_original (req.tile_original),
      .req_bot_kind      (req.bot_kind),
      .req_bot_cell      (req.bot_cell),
      .req_bot_attribute (req.bot_attribute),
      .req_won_at_start  (req.won_at_start),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_state_key     (rsp.state_key)
   );

endmodule
